/* src/svpwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_pkg
// shared constants, tables and helpers for the svpwm duty generator
// ----------------------------------------------------------------------------
package svpwm_pkg;

    // fraction bits of every q value
    localparam int QB = 24;

    // quotient bits produced by the divider before saturation
    localparam int QUO_W = 31;
    // divider depth: operand prep, one stage per quotient bit, output stage
    localparam int DIV_LAT = QUO_W + 2;

    localparam int CORDIC_STEPS = 24;
    // cordic runs in q30
    localparam int CORDIC_SH = 30 - QB;

    localparam logic signed [30:0] TURN_GAIN   = 31'sd683565276;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] CORDIC_RND  = 34'sd1 <<< (CORDIC_SH - 1);

    localparam logic signed [25:0] SQRT3_Q =
        26'((64'd1732051 << QB) / 64'd1000000);
    localparam logic signed [35:0] ONE_Q  = 36'sd1 <<< QB;
    localparam logic signed [39:0] HALF_Q = 40'sd1 <<< (QB - 1);
    localparam logic [23:0] DUTY_MAX = 24'(HALF_Q);

    localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic signed [32:0] ATAN_TURNS [CORDIC_STEPS] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004757,
        33'sd42667331,  33'sd21354465,  33'sd10679839,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81
    };

    // sector codes
    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;
    localparam logic [2:0] SECT_5 = 3'd5;

    // indexed by {-t > beta, t > beta, beta > 0}
    localparam logic [2:0] SECTOR_MAP [8] = '{
        SECT_0, SECT_1, SECT_5, SECT_0, SECT_3, SECT_2, SECT_4, SECT_0
    };

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // divide by 2^k, truncating toward zero
    function automatic logic signed [39:0] div_pow2(input logic signed [39:0] v,
                                                    input int unsigned k);
        logic signed [39:0] bias;
        bias = (v < 0) ? ((40'sd1 <<< k) - 40'sd1) : 40'sd0;
        return (v + bias) >>> k;
    endfunction

    // clamp to 0 .. one half period
    function automatic logic [23:0] clamp_duty(input logic signed [39:0] v);
        logic [23:0] r;
        if (v < 0)
        begin
            r = 24'd0;
        end
        else if (v > HALF_Q)
        begin
            r = DUTY_MAX;
        end
        else
        begin
            r = 24'(v);
        end
        return r;
    endfunction

endpackage

/* src/svpwm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_div
// pipelined signed q divide, (num << QB) / den, saturated to 32 bits
// ----------------------------------------------------------------------------
module svpwm_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 31
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic signed [31:0]      quo
);

    localparam int QW  = svpwm_pkg::QUO_W;
    localparam int NW  = NUM_W + svpwm_pkg::QB;
    localparam int RW  = NW - QW;
    localparam int CW  = ((RW > DEN_W) ? RW : DEN_W) + 1;

    logic [NUM_W-1:0] mag;
    logic [NW-1:0]    scaled;
    logic [RW-1:0]    rem0;

    logic [DEN_W-1:0] rem_reg [QW+1];
    logic [QW-1:0]    quo_reg [QW+1];
    logic [QW-1:0]    lo_reg  [QW+1];
    logic [DEN_W-1:0] den_reg [QW+1];
    logic             sgn_reg [QW+1];
    logic             ovf_reg [QW+1];
    logic signed [31:0] out_reg;

    assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign scaled = {mag, {svpwm_pkg::QB{1'b0}}};
    assign rem0   = scaled[NW-1:QW];

    // operand prep and overflow check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DEN_W'(rem0);
            quo_reg[0] <= '0;
            lo_reg[0]  <= scaled[QW-1:0];
            den_reg[0] <= den;
            sgn_reg[0] <= num[NUM_W-1];
            ovf_reg[0] <= CW'(rem0) >= CW'(den);
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic           take;
        assign trial = {rem_reg[k], lo_reg[k][QW-1-k]};
        assign take  = trial >= {1'b0, den_reg[k]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? DEN_W'(trial - {1'b0, den_reg[k]})
                                     : DEN_W'(trial);
                quo_reg[k+1] <= {quo_reg[k][QW-2:0], take};
                lo_reg[k+1]  <= lo_reg[k];
                den_reg[k+1] <= den_reg[k];
                sgn_reg[k+1] <= sgn_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ovf_reg[QW])
            begin
                out_reg <= sgn_reg[QW] ? svpwm_pkg::SAT_MIN : svpwm_pkg::SAT_MAX;
            end
            else if (sgn_reg[QW])
            begin
                out_reg <= -$signed({1'b0, quo_reg[QW]});
            end
            else
            begin
                out_reg <= $signed({1'b0, quo_reg[QW]});
            end
        end
    end

    assign quo = out_reg;

endmodule

/* src/svpwm_duty_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_duty_generator
// seven-segment space vector pwm: angle and d/q commands to three
// centre-aligned compare values and the sector
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the output is not stalled,
//   set by the fully pipelined cordic (24 stages) and the two 33-stage
//   dividers in series
// a stalled output freezes the whole pipeline; nothing is dropped
// reset clears the valid bits only; data registers are not reset
// ----------------------------------------------------------------------------
module svpwm_duty_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [26:0] rotor_angle,
    input  logic signed [31:0] volt_d,
    input  logic signed [31:0] volt_q,
    input  logic [30:0]        bus_voltage,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [23:0]        duty_a,
    output logic [23:0]        duty_b,
    output logic [23:0]        duty_c,
    output logic [2:0]         sector
);

    localparam int NSTEP = svpwm_pkg::CORDIC_STEPS;
    localparam int DLAT  = svpwm_pkg::DIV_LAT;
    localparam int QB    = svpwm_pkg::QB;
    // phase, quadrant, cordic, rounding, product, sum, scale, sector, div, times,
    // div, output
    localparam int DEPTH = 2 + NSTEP + 5 + DLAT + 1 + DLAT + 1;

    // global advance: every stage moves together unless the output is held
    logic adv;
    logic [DEPTH-1:0] vld_reg;

    assign in_stall  = out_valid && out_stall;
    assign adv       = !in_stall;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // angle to phase in 2^-32 turn; zero bus voltage taken as one lsb
    // ------------------------------------------------------------------
    logic signed [57:0] ph_prod_reg;
    logic signed [31:0] ph_vd_reg, ph_vq_reg;
    logic [30:0]        ph_vb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ph_prod_reg <= 58'(rotor_angle) * 58'(svpwm_pkg::TURN_GAIN);
            ph_vd_reg   <= volt_d;
            ph_vq_reg   <= volt_q;
            ph_vb_reg   <= (bus_voltage == '0) ? 31'd1 : bus_voltage;
        end
    end

    // ------------------------------------------------------------------
    // take out the nearest quarter turn, then cordic one step per stage
    // ------------------------------------------------------------------
    logic [31:0] phase;
    logic [31:0] ph_bias;
    logic [1:0]  quad;
    logic [31:0] resid;

    assign phase   = ph_prod_reg[QB+31:QB];
    assign ph_bias = phase + 32'h2000_0000;
    assign quad    = ph_bias[31:30];
    assign resid   = phase - {quad, 30'd0};

    logic signed [33:0] cx_reg [NSTEP+1];
    logic signed [33:0] cy_reg [NSTEP+1];
    logic signed [32:0] cz_reg [NSTEP+1];
    logic [1:0]         cq_reg [NSTEP+1];
    logic signed [31:0] cvd_reg [NSTEP+1];
    logic signed [31:0] cvq_reg [NSTEP+1];
    logic [30:0]        cvb_reg [NSTEP+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0]  <= svpwm_pkg::CORDIC_GAIN;
            cy_reg[0]  <= '0;
            cz_reg[0]  <= 33'($signed(resid));
            cq_reg[0]  <= quad;
            cvd_reg[0] <= ph_vd_reg;
            cvq_reg[0] <= ph_vq_reg;
            cvb_reg[0] <= ph_vb_reg;
        end
    end

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                // rotate toward zero residual angle
                if (!cz_reg[i][32])
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - svpwm_pkg::ATAN_TURNS[i];
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + svpwm_pkg::ATAN_TURNS[i];
                end
                cq_reg[i+1]  <= cq_reg[i];
                cvd_reg[i+1] <= cvd_reg[i];
                cvq_reg[i+1] <= cvq_reg[i];
                cvb_reg[i+1] <= cvb_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // round q30 to q24 and fold the quadrant back in
    // ------------------------------------------------------------------
    logic signed [27:0] c_rnd, s_rnd;
    logic signed [27:0] cs_next, sn_next;

    assign c_rnd = 28'((cx_reg[NSTEP] + svpwm_pkg::CORDIC_RND) >>> svpwm_pkg::CORDIC_SH);
    assign s_rnd = 28'((cy_reg[NSTEP] + svpwm_pkg::CORDIC_RND) >>> svpwm_pkg::CORDIC_SH);

    always_comb
    begin
        case (cq_reg[NSTEP])
            svpwm_pkg::QUAD_0:
            begin
                cs_next = c_rnd;
                sn_next = s_rnd;
            end
            svpwm_pkg::QUAD_1:
            begin
                cs_next = -s_rnd;
                sn_next = c_rnd;
            end
            svpwm_pkg::QUAD_2:
            begin
                cs_next = -c_rnd;
                sn_next = -s_rnd;
            end
            default:
            begin
                cs_next = s_rnd;
                sn_next = -c_rnd;
            end
        endcase
    end

    logic signed [27:0] cs_reg, sn_reg;
    logic signed [31:0] cs_vd_reg, cs_vq_reg;
    logic [30:0]        cs_vb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cs_reg    <= cs_next;
            sn_reg    <= sn_next;
            cs_vd_reg <= cvd_reg[NSTEP];
            cs_vq_reg <= cvq_reg[NSTEP];
            cs_vb_reg <= cvb_reg[NSTEP];
        end
    end

    // ------------------------------------------------------------------
    // inverse park: four products, then shift and sum
    // ------------------------------------------------------------------
    logic signed [59:0] p_cd_reg, p_sq_reg, p_sd_reg, p_cq_reg;
    logic [30:0]        pr_vb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_cd_reg  <= 60'(cs_reg) * 60'(cs_vd_reg);
            p_sq_reg  <= 60'(sn_reg) * 60'(cs_vq_reg);
            p_sd_reg  <= 60'(sn_reg) * 60'(cs_vd_reg);
            p_cq_reg  <= 60'(cs_reg) * 60'(cs_vq_reg);
            pr_vb_reg <= cs_vb_reg;
        end
    end

    logic signed [33:0] alfa_reg, beta_reg;
    logic [30:0]        ab_vb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alfa_reg  <= 34'(p_cd_reg >>> QB) - 34'(p_sq_reg >>> QB);
            beta_reg  <= 34'(p_sd_reg >>> QB) + 34'(p_cq_reg >>> QB);
            ab_vb_reg <= pr_vb_reg;
        end
    end

    // ------------------------------------------------------------------
    // sqrt(3) scaling of alpha and beta
    // ------------------------------------------------------------------
    logic signed [59:0] pt_reg, pb_reg;
    logic signed [33:0] sq_alfa_reg, sq_beta_reg;
    logic [30:0]        sq_vb_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg      <= 60'(alfa_reg) * 60'(svpwm_pkg::SQRT3_Q);
            pb_reg      <= 60'(beta_reg) * 60'(svpwm_pkg::SQRT3_Q);
            sq_alfa_reg <= alfa_reg;
            sq_beta_reg <= beta_reg;
            sq_vb_reg   <= ab_vb_reg;
        end
    end

    // ------------------------------------------------------------------
    // sector from three sign tests; dividends for x and 1.5*alpha terms
    // ------------------------------------------------------------------
    logic signed [34:0] t_one, x_num, th_num;
    logic signed [35:0] a3;
    logic [2:0]         sec_idx;

    assign t_one  = 35'(pt_reg >>> QB);
    assign x_num  = 35'(pb_reg >>> QB);
    // 1.5 * alpha in q form is floor(3 * alpha / 2)
    assign a3     = 36'(sq_alfa_reg) + 36'(sq_alfa_reg) + 36'(sq_alfa_reg);
    assign th_num = 35'(a3 >>> 1);
    assign sec_idx = {(-36'(t_one)) > 36'(sq_beta_reg),
                      36'(t_one) > 36'(sq_beta_reg),
                      sq_beta_reg > 34'sd0};

    logic signed [34:0] xn_reg, tn_reg;
    logic [30:0]        dv_vb_reg;
    logic [2:0]         dv_sec_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xn_reg     <= x_num;
            tn_reg     <= th_num;
            dv_vb_reg  <= sq_vb_reg;
            dv_sec_reg <= svpwm_pkg::SECTOR_MAP[sec_idx];
        end
    end

    // ------------------------------------------------------------------
    // normalise by bus voltage
    // ------------------------------------------------------------------
    logic signed [31:0] xt, tt;
    logic [2:0]         sd1_reg [DLAT];

    svpwm_div #(.NUM_W(35), .DEN_W(31)) u_div_x (
        .clk (clk),
        .en  (adv),
        .num (xn_reg),
        .den (dv_vb_reg),
        .quo (xt)
    );

    svpwm_div #(.NUM_W(35), .DEN_W(31)) u_div_t (
        .clk (clk),
        .en  (adv),
        .num (tn_reg),
        .den (dv_vb_reg),
        .quo (tt)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd1_reg[0] <= dv_sec_reg;
            for (int k = 1; k < DLAT; k++)
            begin
                sd1_reg[k] <= sd1_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // x, y, z times and the two active times of the sector
    // ------------------------------------------------------------------
    logic signed [31:0] xh;
    logic signed [32:0] yt, zt;
    logic signed [33:0] t1_next, t2_next;
    logic signed [34:0] t0_next;

    assign xh = 32'(svpwm_pkg::div_pow2(40'(xt), 1));
    assign yt = 33'(tt) + 33'(xh);
    assign zt = 33'(xh) - 33'(tt);

    always_comb
    begin
        case (sd1_reg[DLAT-1])
            svpwm_pkg::SECT_0:
            begin
                t1_next = -34'(zt);
                t2_next = 34'(xt);
            end
            svpwm_pkg::SECT_1:
            begin
                t1_next = 34'(zt);
                t2_next = 34'(yt);
            end
            svpwm_pkg::SECT_2:
            begin
                t1_next = 34'(xt);
                t2_next = -34'(yt);
            end
            svpwm_pkg::SECT_3:
            begin
                t1_next = -34'(xt);
                t2_next = 34'(zt);
            end
            svpwm_pkg::SECT_4:
            begin
                t1_next = -34'(yt);
                t2_next = -34'(zt);
            end
            default:
            begin
                t1_next = 34'(yt);
                t2_next = -34'(xt);
            end
        endcase
    end

    assign t0_next = 35'(t1_next) + 35'(t2_next);

    logic signed [33:0] t1_reg, t2_reg;
    logic signed [34:0] t0_reg;
    logic               big_reg;
    logic [2:0]         ts_sec_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg     <= t1_next;
            t2_reg     <= t2_next;
            t0_reg     <= t0_next;
            // overmodulation: active times exceed one period
            big_reg    <= 36'(t0_next) > svpwm_pkg::ONE_Q;
            ts_sec_reg <= sd1_reg[DLAT-1];
        end
    end

    // ------------------------------------------------------------------
    // rescale both active times by their sum; used only when over one
    // ------------------------------------------------------------------
    logic signed [31:0] q1, q2;
    logic signed [33:0] t1d_reg [DLAT];
    logic signed [33:0] t2d_reg [DLAT];
    logic               bigd_reg [DLAT];
    logic [2:0]         secd_reg [DLAT];

    svpwm_div #(.NUM_W(34), .DEN_W(35)) u_div_t1 (
        .clk (clk),
        .en  (adv),
        .num (t1_reg),
        .den (35'(unsigned'(t0_reg))),
        .quo (q1)
    );

    svpwm_div #(.NUM_W(34), .DEN_W(35)) u_div_t2 (
        .clk (clk),
        .en  (adv),
        .num (t2_reg),
        .den (35'(unsigned'(t0_reg))),
        .quo (q2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1d_reg[0]  <= t1_reg;
            t2d_reg[0]  <= t2_reg;
            bigd_reg[0] <= big_reg;
            secd_reg[0] <= ts_sec_reg;
            for (int k = 1; k < DLAT; k++)
            begin
                t1d_reg[k]  <= t1d_reg[k-1];
                t2d_reg[k]  <= t2d_reg[k-1];
                bigd_reg[k] <= bigd_reg[k-1];
                secd_reg[k] <= secd_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // centre-aligned compare values, clamped, routed to phases
    // ------------------------------------------------------------------
    logic signed [33:0] u1, u2;
    logic signed [35:0] t0f;
    logic signed [36:0] d0, d1, d2;
    logic [23:0]        c0, c1, c2;
    logic [23:0]        da_next, db_next, dc_next;

    assign u1  = bigd_reg[DLAT-1] ? 34'(q1) : t1d_reg[DLAT-1];
    assign u2  = bigd_reg[DLAT-1] ? 34'(q2) : t2d_reg[DLAT-1];
    assign t0f = svpwm_pkg::ONE_Q - 36'(u1) - 36'(u2);
    assign d0  = 37'(svpwm_pkg::div_pow2(40'(t0f), 2));
    assign d1  = d0 + 37'(svpwm_pkg::div_pow2(40'(u1), 1));
    assign d2  = d1 + 37'(svpwm_pkg::div_pow2(40'(u2), 1));
    assign c0  = svpwm_pkg::clamp_duty(40'(d0));
    assign c1  = svpwm_pkg::clamp_duty(40'(d1));
    assign c2  = svpwm_pkg::clamp_duty(40'(d2));

    always_comb
    begin
        case (secd_reg[DLAT-1])
            svpwm_pkg::SECT_0:
            begin
                da_next = c0;
                db_next = c1;
                dc_next = c2;
            end
            svpwm_pkg::SECT_1:
            begin
                db_next = c0;
                da_next = c1;
                dc_next = c2;
            end
            svpwm_pkg::SECT_2:
            begin
                db_next = c0;
                dc_next = c1;
                da_next = c2;
            end
            svpwm_pkg::SECT_3:
            begin
                dc_next = c0;
                db_next = c1;
                da_next = c2;
            end
            svpwm_pkg::SECT_4:
            begin
                dc_next = c0;
                da_next = c1;
                db_next = c2;
            end
            default:
            begin
                da_next = c0;
                dc_next = c1;
                db_next = c2;
            end
        endcase
    end

    logic [23:0] duty_a_reg, duty_b_reg, duty_c_reg;
    logic [2:0]  sector_reg;

    // output register: last pipeline stage, holds while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            duty_a_reg <= da_next;
            duty_b_reg <= db_next;
            duty_c_reg <= dc_next;
            sector_reg <= secd_reg[DLAT-1];
        end
    end

    assign duty_a = duty_a_reg;
    assign duty_b = duty_b_reg;
    assign duty_c = duty_c_reg;
    assign sector = sector_reg;

endmodule

/* src/svpwm_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_chk
// port-level checks for the svpwm duty generator
// ----------------------------------------------------------------------------
module svpwm_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] duty_a,
    input logic [23:0] duty_b,
    input logic [23:0] duty_c,
    input logic [2:0]  sector
);

    // held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(duty_a) && $stable(duty_b)
                                   && $stable(duty_c) && $stable(sector))
        else $error("held result changed");

    // input side only backs up when the output is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_sector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sector <= svpwm_pkg::SECT_5)
        else $error("sector out of range");

    a_duty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> duty_a <= svpwm_pkg::DUTY_MAX && duty_b <= svpwm_pkg::DUTY_MAX
                      && duty_c <= svpwm_pkg::DUTY_MAX)
        else $error("duty above half period");

endmodule

bind svpwm_duty_generator svpwm_chk u_svpwm_chk (.*);

/* test/svpwm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_checker
// watches both channels of the svpwm duty generator, predicts the compare
// values and sector of every accepted request and compares them in order
// ----------------------------------------------------------------------------
module svpwm_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [26:0] rotor_angle,
    input  logic signed [31:0] volt_d,
    input  logic signed [31:0] volt_q,
    input  logic [30:0]        bus_voltage,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [23:0]        duty_a,
    input  logic [23:0]        duty_b,
    input  logic [23:0]        duty_c,
    input  logic [2:0]         sector,
    output int                 errors,
    output int                 pending,
    output int                 seen
);

    typedef struct packed {
        logic [23:0] a;
        logic [23:0] b;
        logic [23:0] c;
        logic [2:0]  s;
    } duty_set_t;

    duty_set_t duty_q[$];

    localparam int QB = svpwm_pkg::QB;
    localparam longint ONE = 64'sd1 <<< QB;

    // floor shift for signed values
    function automatic longint fshr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return fshr(a * b, QB);
    endfunction

    function automatic longint qdiv_sat(input longint a, input longint b);
        longint r;
        r = (a * ONE) / b;
        if (r > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        if (r < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic duty_set_t predict_duty(input longint ang, input longint vd,
                                               input longint vq, input longint vb);
        longint atans [24];
        logic [31:0] ph, u;
        logic [1:0] quad;
        longint z, x, y, dx, dy, c, sn, cs, al, be, t, xt, tt, yt, zt;
        longint t1, t2, t0, sq3, dv [3];
        int idx, f, g, h;
        logic [2:0] sect;
        duty_set_t r;
        for (int i = 0; i < 24; i++)
        begin
            atans[i] = svpwm_pkg::ATAN_TURNS[i];
        end
        if (vb == 0)
        begin
            vb = 1;
        end
        ph = 32'((ang * 64'sd683565276) >>> QB);
        quad = 2'((ph + 32'h2000_0000) >> 30);
        u = ph - (32'(quad) << 30);
        z = longint'(signed'(u));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 24; i++)
        begin
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atans[i];
            end
            else
            begin
                x += dx; y -= dy; z += atans[i];
            end
        end
        c = fshr(x + (64'sd1 <<< (29 - QB)), 30 - QB);
        sn = fshr(y + (64'sd1 <<< (29 - QB)), 30 - QB);
        case (quad)
            svpwm_pkg::QUAD_0:  begin cs = c;   end
            svpwm_pkg::QUAD_1:  begin cs = -sn; sn = c;  end
            svpwm_pkg::QUAD_2:  begin cs = -c;  sn = -sn; end
            default: begin cs = sn;  sn = -c; end
        endcase
        sq3 = (64'd1732051 << QB) / 64'd1000000;
        al = qmul(cs, vd) - qmul(sn, vq);
        be = qmul(sn, vd) + qmul(cs, vq);
        t = qmul(al, sq3);
        idx = (be > 0 ? 1 : 0) + (t > be ? 2 : 0) + (-t > be ? 4 : 0);
        case (idx)
            1: sect = svpwm_pkg::SECT_1;
            2: sect = svpwm_pkg::SECT_5;
            4: sect = svpwm_pkg::SECT_3;
            5: sect = svpwm_pkg::SECT_2;
            6: sect = svpwm_pkg::SECT_4;
            default: sect = svpwm_pkg::SECT_0;
        endcase
        xt = qdiv_sat(qmul(sq3, be), vb);
        tt = qdiv_sat(qmul(64'sd3 <<< (QB - 1), al), vb);
        yt = tt + xt / 2;
        zt = xt / 2 - tt;
        case (sect)
            svpwm_pkg::SECT_0:  begin t1 = -zt; t2 = xt;  f = 0; g = 1; h = 2; end
            svpwm_pkg::SECT_1:  begin t1 = zt;  t2 = yt;  f = 1; g = 0; h = 2; end
            svpwm_pkg::SECT_2:  begin t1 = xt;  t2 = -yt; f = 1; g = 2; h = 0; end
            svpwm_pkg::SECT_3:  begin t1 = -xt; t2 = zt;  f = 2; g = 1; h = 0; end
            svpwm_pkg::SECT_4:  begin t1 = -yt; t2 = -zt; f = 2; g = 0; h = 1; end
            default: begin t1 = yt;  t2 = -xt; f = 0; g = 2; h = 1; end
        endcase
        t0 = t1 + t2;
        if (t0 > ONE)
        begin
            t1 = qdiv_sat(t1, t0);
            t2 = qdiv_sat(t2, t0);
        end
        t0 = ONE - t1 - t2;
        dv[f] = t0 / 4;
        dv[g] = dv[f] + t1 / 2;
        dv[h] = dv[g] + t2 / 2;
        for (int k = 0; k < 3; k++)
        begin
            if (dv[k] < 0)
            begin
                dv[k] = 0;
            end
            if (dv[k] > ONE / 2)
            begin
                dv[k] = ONE / 2;
            end
        end
        r.a = 24'(dv[0]);
        r.b = 24'(dv[1]);
        r.c = 24'(dv[2]);
        r.s = sect;
        return r;
    endfunction

    assign pending = duty_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        duty_set_t exp_set;
        if (!rst_n)
        begin
            errors <= 0;
            seen <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                duty_q.push_back(predict_duty(rotor_angle, volt_d, volt_q,
                                              longint'(bus_voltage)));
            end
            if (out_valid && !out_stall)
            begin
                seen <= seen + 1;
                if (duty_q.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("unexpected result a=%0d b=%0d c=%0d s=%0d",
                                 duty_a, duty_b, duty_c, sector);
                    end
                    errors <= errors + 1;
                end
                else
                begin
                    exp_set = duty_q.pop_front();
                    if (exp_set != {duty_a, duty_b, duty_c, sector})
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch exp a=%0d b=%0d c=%0d s=%0d",
                                     exp_set.a, exp_set.b, exp_set.c, exp_set.s);
                            $display("         got a=%0d b=%0d c=%0d s=%0d",
                                     duty_a, duty_b, duty_c, sector);
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives angle, d/q command and bus voltage requests into the svpwm duty
// generator with random gaps and output stalls; a checker predicts results
// ----------------------------------------------------------------------------
module tb;

    localparam int ANGLE_MAX = 52707179;
    localparam int N_RANDOM = 400;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [26:0] rotor_angle;
    logic signed [31:0] volt_d;
    logic signed [31:0] volt_q;
    logic [30:0]        bus_voltage;
    logic               out_valid;
    logic               out_stall;
    logic [23:0]        duty_a;
    logic [23:0]        duty_b;
    logic [23:0]        duty_c;
    logic [2:0]         sector;
    int                 errors;
    int                 pending;
    int                 seen;
    int                 n_sent;

    svpwm_duty_generator u_top (.*);

    svpwm_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // run limit: a watchdog that ends the run with an error
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // output stall: random length per cycle, with stall-free stretches
    initial
    begin
        int hold;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (n_sent > 150 && n_sent < 250)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                hold = $urandom_range(0, 3);
                if (hold != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (hold)
                    begin
                        @(posedge clk);
                    end
                end
                out_stall <= 1'b0;
            end
        end
    end

    // one request, held until accepted, then a random gap
    task automatic send_request(input logic signed [26:0] ang,
                                input logic signed [31:0] vd,
                                input logic signed [31:0] vq,
                                input logic [30:0] vb);
        int gap;
        in_valid <= 1'b1;
        rotor_angle <= ang;
        volt_d <= vd;
        volt_q <= vq;
        bus_voltage <= vb;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        n_sent++;
        gap = (n_sent > 150 && n_sent < 250) ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
            begin
                @(posedge clk);
            end
        end
    endtask

    function automatic logic signed [31:0] rand_volt();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $signed(32'($urandom_range(0, 2 ** 26))) - 32'sd33554432;
            default: return $signed(32'($urandom_range(0, 2 ** 25))) - 32'sd16777216;
        endcase
    endfunction

    function automatic logic [30:0] rand_bus();
        case ($urandom_range(0, 3))
            0:       return 31'($urandom);
            1:       return 31'($urandom_range(1, 1000));
            default: return 31'($urandom_range(2 ** 24, 2 ** 30));
        endcase
    endfunction

    initial
    begin
        n_sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        rotor_angle = '0;
        volt_d = '0;
        volt_q = '0;
        bus_voltage = 31'd1;
        repeat (5)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // zero vector, all-ones angle bits, zero bus, extremes of each field
        send_request(27'sd0, 32'sd0, 32'sd0, 31'd16777216);
        send_request(27'sd0, 32'sd0, 32'sd0, 31'd0);
        send_request(27'sd52707179, 32'sd16777216, 32'sd0, 31'h7fffffff);
        send_request(-27'sd52707179, 32'sd16777216, 32'sd0, 31'd1);
        send_request(-27'sd1, 32'sh7fffffff, 32'sh8000_0000, 31'd1);
        send_request(27'sd67108863, 32'sh8000_0000, 32'sh7fffffff, 31'h7fffffff);
        send_request(27'sh400_0000, -32'sd1, -32'sd1, 31'd16777216);
        // overmodulation: active times above one period
        send_request(27'sd8000000, 32'sd50000000, 32'sd50000000, 31'd16777216);
        // one vector inside each sector
        for (int k = 0; k < 6; k++)
        begin
            send_request(27'(-ANGLE_MAX + k * 17569060 + 8784530), 32'sd0,
                         32'sd8388608, 31'd33554432);
        end
        // at a quadrant boundary and at a quarter turn
        send_request(27'sd13176795, 32'sd5000000, -32'sd5000000, 31'd20000000);
        send_request(27'sd26353590, -32'sd5000000, 32'sd5000000, 31'd20000000);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            send_request($urandom_range(0, 4) == 0 ? 27'($urandom)
                         : 27'($signed($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX),
                         rand_volt(), rand_volt(), rand_bus());
        end
        in_valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (120)
        begin
            @(posedge clk);
        end
        $display("sent %0d requests, %0d results checked", n_sent, seen);
        $display("covered all sectors, overmodulation, saturation and zero bus");
        if (errors == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
